### rtl/core/cdf_pkg.sv
`default_nettype none
package cdf_pkg;

  // Wide signed intermediate, holds any value within +-2^61.
  typedef logic signed [62:0] big_t;

  localparam big_t BIG_LIMIT = 63'sd2305843009213693952;

  localparam logic [19:0] MIN_SMOOTH      = 20'd7;
  localparam logic [19:0] RESET_SMOOTH    = 20'd7864;
  localparam logic [30:0] RESET_MAX_SPEED = 31'd19660800;
  localparam logic [15:0] COEF_SQ         = 16'd31457;
  localparam logic [15:0] COEF_CU         = 16'd15401;
  localparam logic [26:0] X_CAP           = 27'd67108864;

  localparam logic [7:0] REG_SMOOTH_TIME = 8'd0;
  localparam logic [7:0] REG_MAX_SPEED   = 8'd1;

  // Coefficients shared by all three axis lanes for one item.
  typedef struct packed {
    logic [30:0] omega;
    logic [15:0] dt;
    logic [32:0] expo;
    logic [34:0] maxc;
  } lane_coef_t;

  function automatic big_t sat_big(input logic signed [63:0] v);
    if (v > 64'sd2305843009213693952) begin
      return BIG_LIMIT;
    end else if (v < -64'sd2305843009213693952) begin
      return -BIG_LIMIT;
    end
    return v[62:0];
  endfunction

  function automatic logic signed [31:0] sat32(input big_t v);
    if (v > 63'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -63'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/cdf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// 33 bits, which holds when the top 16 numerator bits are below the divisor.
module cdf_div import cdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [48:0] num,
  input  wire logic [44:0] dvs,
  output logic      [32:0] quo,
  output logic             done
);

  logic [44:0] rem;
  logic [44:0] dvs_q;
  logic [32:0] nsh;
  logic [5:0]  cnt;
  logic        busy;
  logic [45:0] trial;
  logic        ge;

  assign trial = {rem, nsh[32]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem   <= {29'b0, num[48:33]};
        nsh   <= num[32:0];
        dvs_q <= dvs;
        cnt   <= 6'd33;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 45'(trial - {1'b0, dvs_q}) : trial[44:0];
        quo <= {quo[31:0], ge};
        nsh <= {nsh[31:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/cdf_mul.sv
`default_nettype none
// Sequential signed-by-unsigned multiplier, eight multiplier bits per cycle.
// The product is shifted right by 16 or 32, truncated toward zero and
// saturated to +-2^61; a raw product of 2^64 or more also saturates.
module cdf_mul import cdf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire big_t        a,
  input  wire logic [32:0] b,
  input  wire logic        shift32,
  output big_t             res,
  output logic             done
);

  logic [61:0]  ua;
  logic         neg;
  logic         sh;
  logic [39:0]  bq;
  logic [101:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [69:0]  pp;
  logic [63:0]  shifted;
  logic [61:0]  mag;
  logic [62:0]  a_abs;

  assign a_abs   = a[62] ? 63'(-a) : a;
  assign pp      = ua * bq[39:32];
  assign shifted = sh ? acc[95:32] : acc[79:16];

  always_comb begin
    if ((|acc[101:64]) || shifted > 64'd2305843009213693952) begin
      mag = 62'd2305843009213693952;
    end else begin
      mag = shifted[61:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        ua   <= a_abs[61:0];
        neg  <= a[62];
        sh   <= shift32;
        bq   <= {7'b0, b};
        acc  <= '0;
        cnt  <= 3'd5;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd0) begin
          acc <= {acc[93:0], 8'b0} + {32'b0, pp};
          bq  <= {bq[31:0], 8'b0};
          cnt <= cnt - 3'd1;
        end else begin
          res  <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/cdf_lane.sv
`default_nettype none
// One axis of the follow filter: holds its position and velocity and runs
// the five products of one update through its own multiplier.
module cdf_lane import cdf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire lane_coef_t         coef,
  input  wire logic signed [31:0] target,
  output logic signed [31:0]      pos,
  output logic                    done
);

  typedef enum logic [3:0] {
    L_IDLE  = 4'b0001,
    L_ISSUE = 4'b0010,
    L_WAIT  = 4'b0100,
    L_FIN   = 4'b1000
  } lane_state_t;

  localparam logic [2:0] ST_DRIVE = 3'd0;
  localparam logic [2:0] ST_TMP   = 3'd1;
  localparam logic [2:0] ST_DAMP  = 3'd2;
  localparam logic [2:0] ST_VEL   = 3'd3;
  localparam logic [2:0] ST_POS   = 3'd4;

  lane_state_t        state;
  logic [2:0]         step;
  logic signed [31:0] vel;
  logic signed [32:0] c;
  logic signed [33:0] lim;
  big_t               s1, tmp, s3, vn, o;
  logic signed [32:0] diff;
  logic signed [35:0] diff_x, maxc_x, cc;
  big_t               mul_a, mul_res, ct;
  logic [32:0]        mul_b;
  logic               mul_sh, mul_go, mul_done, over;

  assign diff   = {pos[31], pos} - {target[31], target};
  assign diff_x = 36'(diff);
  assign maxc_x = {1'b0, coef.maxc};

  always_comb begin
    if (diff_x > maxc_x) begin
      cc = maxc_x;
    end else if (diff_x < -maxc_x) begin
      cc = -maxc_x;
    end else begin
      cc = diff_x;
    end
  end

  assign ct = sat_big(64'(c) + 64'(tmp));

  always_comb begin
    mul_a  = 63'(c);
    mul_b  = {2'b0, coef.omega};
    mul_sh = 1'b0;
    unique case (step)
      ST_TMP: begin
        mul_a = s1;
        mul_b = {17'b0, coef.dt};
      end
      ST_DAMP: begin
        mul_a = tmp;
      end
      ST_VEL: begin
        mul_a  = s3;
        mul_b  = coef.expo;
        mul_sh = 1'b1;
      end
      ST_POS: begin
        mul_a  = ct;
        mul_b  = coef.expo;
        mul_sh = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mul_go = state == L_ISSUE;
  // Overshoot: the new position lands on the far side of the target.
  assign over = (target > pos) == (o > 63'(target));

  cdf_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .shift32 (mul_sh),
    .res     (mul_res),
    .done    (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      step  <= ST_DRIVE;
      pos   <= '0;
      vel   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (go) begin
            c     <= cc[32:0];
            lim   <= 34'(pos) - 34'(cc);
            step  <= ST_DRIVE;
            state <= L_ISSUE;
          end
        end
        L_ISSUE: begin
          state <= L_WAIT;
        end
        L_WAIT: begin
          if (mul_done) begin
            unique case (step)
              ST_DRIVE: s1  <= sat_big(64'(vel) + 64'(mul_res));
              ST_TMP:   tmp <= mul_res;
              ST_DAMP:  s3  <= sat_big(64'(vel) - 64'(mul_res));
              ST_VEL:   vn  <= mul_res;
              default:  o   <= sat_big(64'(lim) + 64'(mul_res));
            endcase
            if (step == ST_POS) begin
              state <= L_FIN;
            end else begin
              step  <= step + 3'd1;
              state <= L_ISSUE;
            end
          end
        end
        L_FIN: begin
          if (over) begin
            pos <= target;
            vel <= '0;
          end else begin
            pos <= sat32(o);
            vel <= sat32(vn);
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/critically_damped_follow_filter.sv
// Three-axis critically damped follow filter.
// Input stream: one transaction per step carries the x, y and z targets and
// the step time; output stream: one transaction per step carries the new
// x, y and z positions. Configuration writes (index 0 smooth_time, index 1
// max_speed) go over the cfg channel, which is always ready; other indexes
// are ignored. After reset, and after every write to smooth_time or
// max_speed, the block computes omega = 2/smooth_time with its serial
// divider before it takes the next item.
// From acceptance to output, an item passes through the decay polynomial
// (x, its square and cube, then the denominator), the divider that forms
// the decay factor, the three axis lanes, each of which runs five products
// through its own 8-bit-per-cycle multiplier, and a step that merges the
// lanes. One item is worked on at a time; the next can be accepted in the
// cycle after the result enters the output register. A stalled result
// holds its data, and the following result waits in the merge step until
// the register frees.
// Reset zeroes the positions and velocities and loads the default
// configuration.
`default_nettype none
module critically_damped_follow_filter import cdf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // target_x, target_y, target_z, step_time
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x, pos_y, pos_z
  output logic [95:0]       m_axis_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  typedef enum logic [9:0] {
    F_IDLE   = 10'b0000000001,
    F_PREP   = 10'b0000000010,
    F_OMEGA  = 10'b0000000100,
    F_X      = 10'b0000001000,
    F_X2     = 10'b0000010000,
    F_X3     = 10'b0000100000,
    F_DEN    = 10'b0001000000,
    F_EXPO   = 10'b0010000000,
    F_LANES  = 10'b0100000000,
    F_MERGE  = 10'b1000000000
  } front_state_t;

  front_state_t       state;
  logic [19:0]        smooth_time;
  logic [30:0]        max_speed;
  logic               dirty;
  logic [30:0]        omega;
  logic [34:0]        maxc;
  logic [15:0]        dt;
  logic signed [31:0] tgt [3];
  logic [26:0]        x;
  logic [36:0]        x2;
  logic [46:0]        x3;
  logic [44:0]        den;
  logic [32:0]        expo;
  logic               lane_go;
  logic [2:0]         lane_done;
  logic [2:0]         done_vec;
  logic signed [31:0] lane_pos [3];
  lane_coef_t         coef;

  logic [19:0] st_eff;
  logic [46:0] xw;
  logic [53:0] xx;
  logic [63:0] x2x;
  logic [52:0] t2;
  logic [62:0] t3;
  logic [47:0] den_sum;
  logic [50:0] ms;
  logic        div_go, div_done, in_acc, out_free;
  logic [48:0] div_num;
  logic [44:0] div_dvs;
  logic [32:0] quo;

  assign st_eff  = (smooth_time < MIN_SMOOTH) ? MIN_SMOOTH : smooth_time;
  assign xw      = omega * dt;
  assign xx      = x * x;
  assign x2x     = x2 * x;
  assign t2      = COEF_SQ * x2;
  assign t3      = COEF_CU * x3;
  assign den_sum = 48'd65536 + 48'(x) + 48'(t2[52:16]) + 48'(t3[62:16]);
  assign ms      = max_speed * st_eff;

  // The decay denominator is formed from the registered cube in F_DEN and
  // captured by the divider when it starts.
  assign den = den_sum[44:0];

  assign div_go  = (state == F_PREP) || (state == F_DEN);
  assign div_num = (state == F_PREP) ? (49'd1 << 33) : (49'd1 << 48);
  assign div_dvs = (state == F_PREP) ? {25'b0, st_eff} : den;

  assign s_axis_tready = (state == F_IDLE) && !dirty;
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign coef.omega = omega;
  assign coef.dt    = dt;
  assign coef.expo  = expo;
  assign coef.maxc  = maxc;

  cdf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .dvs  (div_dvs),
    .quo  (quo),
    .done (div_done)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cdf_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .go     (lane_go),
      .coef   (coef),
      .target (tgt[k]),
      .pos    (lane_pos[k]),
      .done   (done_vec[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      smooth_time   <= RESET_SMOOTH;
      max_speed     <= RESET_MAX_SPEED;
      dirty         <= 1'b1;
      lane_go       <= 1'b0;
      lane_done     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      lane_go <= 1'b0;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == F_PREP) begin
        dirty <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SMOOTH_TIME: begin
            smooth_time <= cfg_data[19:0];
            dirty       <= 1'b1;
          end
          REG_MAX_SPEED: begin
            max_speed <= cfg_data[30:0];
            dirty     <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (dirty) begin
            state <= F_PREP;
          end else if (in_acc) begin
            tgt[0] <= s_axis_tdata[31:0];
            tgt[1] <= s_axis_tdata[63:32];
            tgt[2] <= s_axis_tdata[95:64];
            dt     <= s_axis_tdata[111:96];
            state  <= F_X;
          end
        end
        F_PREP: begin
          maxc  <= ms[50:16];
          state <= F_OMEGA;
        end
        F_OMEGA: begin
          if (div_done) begin
            omega <= quo[30:0];
            state <= F_IDLE;
          end
        end
        F_X: begin
          x     <= (xw[46:16] > 31'(X_CAP)) ? X_CAP : xw[42:16];
          state <= F_X2;
        end
        F_X2: begin
          x2    <= xx[52:16];
          state <= F_X3;
        end
        F_X3: begin
          x3    <= x2x[62:16];
          state <= F_DEN;
        end
        F_DEN: begin
          state <= F_EXPO;
        end
        F_EXPO: begin
          if (div_done) begin
            expo    <= quo;
            lane_go <= 1'b1;
            state   <= F_LANES;
          end
        end
        F_LANES: begin
          lane_done <= lane_done | done_vec;
          if ((lane_done | done_vec) == 3'b111) begin
            state <= F_MERGE;
          end
        end
        F_MERGE: begin
          if (out_free) begin
            m_axis_tdata  <= {lane_pos[2], lane_pos[1], lane_pos[0]};
            m_axis_tvalid <= 1'b1;
            lane_done     <= '0;
            state         <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    done_vec == 3'b000 || done_vec == 3'b111)
    else $error("axis lanes finished out of step");

  a_merge_free: assert property (@(posedge clk) disable iff (rst)
    (state == F_MERGE && out_free) |=> m_axis_tvalid)
    else $error("result not presented after merge");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == F_OMEGA || state == F_EXPO))
    else $error("divider finished with no consumer waiting");

endmodule
`default_nettype wire

### dv/tb_critically_damped_follow_filter.sv
`default_nettype none
module tb_critically_damped_follow_filter;
  import cdf_pkg::*;

  localparam logic [7:0] REG_UNUSED = 8'd5;
  localparam longint FIXED_LIMIT = 64'sd2305843009213693952;

  typedef struct packed {
    logic [15:0] dt;
    logic [31:0] tz;
    logic [31:0] ty;
    logic [31:0] tx;
  } target_item_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } position_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_index;
  logic [31:0]  cfg_data;

  critically_damped_follow_filter u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  target_item_t target_q[$];
  position_t    pos_expected[$];
  int           mismatches;
  int           results_seen;
  bit           no_idle;

  // Shadow state of the filter.
  logic [19:0] smooth_sh;
  logic [30:0] speed_sh;
  longint      pos_sh[3];
  longint      vel_sh[3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip61(longint v);
    if (v > FIXED_LIMIT) return FIXED_LIMIT;
    if (v < -FIXED_LIMIT) return -FIXED_LIMIT;
    return v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Signed product scaled down, truncated toward zero, capped at the wide limit.
  function automatic longint fx_mul(longint a, longint b, int sh);
    bit                neg;
    longint unsigned   ua, ub, mag;
    logic [127:0]      prod;
    neg  = (a < 0) != (b < 0);
    ua   = a < 0 ? 64'd0 - a : a;
    ub   = b < 0 ? 64'd0 - b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    if (prod[127:64] != 0) begin
      mag = FIXED_LIMIT;
    end else begin
      mag = prod[63:0] >> sh;
      if (mag > FIXED_LIMIT) mag = FIXED_LIMIT;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic position_t follow_step(target_item_t it);
    longint unsigned st, omega, dt, x, x2, x3, den, expo, maxc;
    longint          tgt[3];
    longint          cur, vel, c, lim, tmp, o;
    position_t       r;
    tgt[0] = longint'(signed'(it.tx));
    tgt[1] = longint'(signed'(it.ty));
    tgt[2] = longint'(signed'(it.tz));
    st    = smooth_sh < MIN_SMOOTH ? MIN_SMOOTH : smooth_sh;
    omega = (64'd1 << 33) / st;
    dt    = it.dt;
    x     = (omega * dt) >> 16;
    if (x > X_CAP) x = X_CAP;
    x2   = (x * x) >> 16;
    x3   = (x2 * x) >> 16;
    den  = 64'd65536 + x + ((COEF_SQ * x2) >> 16) + ((COEF_CU * x3) >> 16);
    expo = (64'd1 << 48) / den;
    maxc = (longint'(speed_sh) * st) >> 16;
    for (int k = 0; k < 3; k++) begin
      cur = pos_sh[k];
      vel = vel_sh[k];
      c   = cur - tgt[k];
      if (c > longint'(maxc)) c = maxc;
      if (c < -longint'(maxc)) c = -longint'(maxc);
      lim = cur - c;
      tmp = fx_mul(clip61(vel + fx_mul(omega, c, 16)), dt, 16);
      vel = fx_mul(clip61(vel - fx_mul(omega, tmp, 16)), expo, 32);
      o   = clip61(lim + fx_mul(clip61(c + tmp), expo, 32));
      // Never pass the target: land on it and stop.
      if ((tgt[k] - cur > 0) == (o > tgt[k])) begin
        o   = tgt[k];
        vel = 0;
      end
      pos_sh[k] = clip32(o);
      vel_sh[k] = clip32(vel);
    end
    r.px = pos_sh[0][31:0];
    r.py = pos_sh[1][31:0];
    r.pz = pos_sh[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH %s at %0t", msg, $time);
    mismatches++;
  endtask

  // Input driver with random gaps.
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pos_expected.push_back(follow_step(target_item_t'(s_axis_tdata)));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (target_q.size() != 0 && !no_idle && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 5);
          s_axis_tvalid <= 1'b0;
        end else if (target_q.size() != 0) begin
          s_axis_tdata  <= target_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random back-pressure; also tracks register writes.
  int stall_left;
  always @(posedge clk) begin
    position_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      smooth_sh = RESET_SMOOTH;
      speed_sh  = RESET_MAX_SPEED;
      for (int k = 0; k < 3; k++) begin
        pos_sh[k] = 0;
        vel_sh[k] = 0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SMOOTH_TIME: smooth_sh = cfg_data[19:0];
          REG_MAX_SPEED:   speed_sh  = cfg_data[30:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pos_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = pos_expected.pop_front();
          if (m_axis_tdata[31:0] !== want.px)
            report_mismatch($sformatf("pos_x: got %h expected %h", m_axis_tdata[31:0], want.px));
          if (m_axis_tdata[63:32] !== want.py)
            report_mismatch($sformatf("pos_y: got %h expected %h", m_axis_tdata[63:32], want.py));
          if (m_axis_tdata[95:64] !== want.pz)
            report_mismatch($sformatf("pos_z: got %h expected %h", m_axis_tdata[95:64], want.pz));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Checked mid-cycle so that every update of the last edge has settled.
  task automatic wait_drained();
    while (target_q.size() != 0 || s_axis_tvalid || pos_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_target(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] dt);
    target_item_t it;
    it.tx = x;
    it.ty = y;
    it.tz = z;
    it.dt = dt;
    target_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3:       return $urandom_range(0, 255) - 128;
      default: return 32'($urandom_range(0, 32'h07ffffff)) - 32'h04000000;
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(1, 65535));
      1:       return $urandom_range(0, 1) ? 16'd1 : 16'hffff;
      default: return 16'($urandom_range(256, 4400));
    endcase
  endfunction

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      // Hold a target for a few steps now and then so the spring settles.
      if (target_q.size() != 0 && $urandom_range(0, 3) == 0) begin
        target_item_t last;
        last = target_q[$];
        add_target(last.tx, last.ty, last.tz, rand_step());
      end else begin
        add_target(rand_target(), rand_target(), rand_target(), rand_step());
      end
    end
  endtask

  logic [19:0] smooth_set[6] = '{20'd7864, 20'd0, 20'd655360, 20'd6, 20'd65536, 20'd3277};
  logic [30:0] speed_set[6]  = '{31'd19660800, 31'h7fffffff, 31'd0, 31'd65536,
                                 31'd655360000, 31'd1};

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    results_seen  = 0;
    no_idle       = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed steps under the reset settings.
    add_target(32'h7fffffff, 32'h80000000, 32'h0, 16'hffff);
    add_target(32'h7fffffff, 32'h80000000, 32'h0, 16'hffff);
    add_target(32'h80000000, 32'h7fffffff, 32'h00010000, 16'd1);
    add_target(32'h0, 32'h0, 32'h0, 16'd0);
    add_target(32'h00640000, 32'hff9c0000, 32'h00000001, 16'd1092);
    add_target(32'h00640000, 32'hff9c0000, 32'h00000001, 16'd0);
    add_target(32'h00640000, 32'hff9c0000, 32'hffffffff, 16'd1092);
    add_target(32'h00640000, 32'hff9c0000, 32'hffffffff, 16'hffff);
    add_target(32'h0, 32'h0, 32'h0, 16'h8000);
    add_target(32'h12345678, 32'hedcba987, 32'h55555555, 16'hAAAA);
    add_target(32'haaaaaaaa, 32'h55555555, 32'hedcba987, 16'h5555);
    wait_drained();

    write_reg(REG_UNUSED, $urandom());
    write_reg(REG_SMOOTH_TIME, 32'd0);
    add_target(32'h00100000, 32'hfff00000, 32'h7fffffff, 16'd1);
    add_target(32'h00100000, 32'hfff00000, 32'h80000000, 16'hffff);
    add_target(32'h80000000, 32'h7fffffff, 32'h0, 16'hffff);
    add_random(15);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      int sel;
      sel = ph % 6;
      if (ph == 7) no_idle = 1'b1;
      write_reg(REG_SMOOTH_TIME, {12'($urandom_range(0, 4095)), smooth_set[sel]});
      write_reg(REG_MAX_SPEED, {1'($urandom_range(0, 1)), speed_set[sel]});
      add_random(55);
      wait_drained();
    end
    repeat (200) @(posedge clk);

    if (pos_expected.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pos_expected.size()));
    end
    $display("Checked %0d position results over eight register settings,", results_seen);
    $display("including tiny and huge smoothing times and zero and full speed limits.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
